// ===== sv/sac_pkg.sv =====
// Shared types, scancode constants and key tables for the scancode decoder.
package sac_pkg;

   // Operation codes of a request
   localparam logic OP_SCANCODE = 1'b0;
   localparam logic OP_READ     = 1'b1;

   // Set-1 scancodes with special meaning
   localparam logic [7:0] SC_PREFIX      = 8'hE0;
   localparam logic [7:0] SC_LSHIFT      = 8'h2A;
   localparam logic [7:0] SC_RSHIFT      = 8'h36;
   localparam logic [7:0] SC_LSHIFT_UP   = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_UP   = 8'hB6;
   localparam logic [7:0] SC_RELEASE_BIT = 8'h80;

   typedef struct packed {
      logic       operation;
      logic [7:0] scancode;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] char_out;
      logic       fifo_empty;
      logic       dropped;
   } rsp_payload_type;

   // Decoder verdict for one scancode byte
   typedef struct packed {
      logic       prefix_set;
      logic       prefix_clr;
      logic       shift_set;
      logic       shift_clr;
      logic       push;
      logic [6:0] ch;
   } dec_type;

   // US layout, no shift
   function automatic logic [6:0] plain_char(input logic [6:0] code);
      logic [6:0] c;
      case (code)
         7'h01: c = 7'h1B;
         7'h02: c = 7'h31;
         7'h03: c = 7'h32;
         7'h04: c = 7'h33;
         7'h05: c = 7'h34;
         7'h06: c = 7'h35;
         7'h07: c = 7'h36;
         7'h08: c = 7'h37;
         7'h09: c = 7'h38;
         7'h0A: c = 7'h39;
         7'h0B: c = 7'h30;
         7'h0C: c = 7'h2D;
         7'h0D: c = 7'h3D;
         7'h0E: c = 7'h08;
         7'h0F: c = 7'h09;
         7'h10: c = 7'h71;
         7'h11: c = 7'h77;
         7'h12: c = 7'h65;
         7'h13: c = 7'h72;
         7'h14: c = 7'h74;
         7'h15: c = 7'h79;
         7'h16: c = 7'h75;
         7'h17: c = 7'h69;
         7'h18: c = 7'h6F;
         7'h19: c = 7'h70;
         7'h1A: c = 7'h5B;
         7'h1B: c = 7'h5D;
         7'h1C: c = 7'h0A;
         7'h1E: c = 7'h61;
         7'h1F: c = 7'h73;
         7'h20: c = 7'h64;
         7'h21: c = 7'h66;
         7'h22: c = 7'h67;
         7'h23: c = 7'h68;
         7'h24: c = 7'h6A;
         7'h25: c = 7'h6B;
         7'h26: c = 7'h6C;
         7'h27: c = 7'h3B;
         7'h28: c = 7'h27;
         7'h29: c = 7'h60;
         7'h2B: c = 7'h5C;
         7'h2C: c = 7'h7A;
         7'h2D: c = 7'h78;
         7'h2E: c = 7'h63;
         7'h2F: c = 7'h76;
         7'h30: c = 7'h62;
         7'h31: c = 7'h6E;
         7'h32: c = 7'h6D;
         7'h33: c = 7'h2C;
         7'h34: c = 7'h2E;
         7'h35: c = 7'h2F;
         7'h37: c = 7'h2A;
         7'h39: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   // US layout with shift held; letters and unchanged keys come from the plain table
   function automatic logic [6:0] shift_char(input logic [6:0] code);
      logic [6:0] c;
      logic [6:0] p;
      p = plain_char(code);
      case (code)
         7'h02: c = 7'h21;
         7'h03: c = 7'h40;
         7'h04: c = 7'h23;
         7'h05: c = 7'h24;
         7'h06: c = 7'h25;
         7'h07: c = 7'h5E;
         7'h08: c = 7'h26;
         7'h09: c = 7'h2A;
         7'h0A: c = 7'h28;
         7'h0B: c = 7'h29;
         7'h0C: c = 7'h5F;
         7'h0D: c = 7'h2B;
         7'h1A: c = 7'h7B;
         7'h1B: c = 7'h7D;
         7'h27: c = 7'h3A;
         7'h28: c = 7'h22;
         7'h29: c = 7'h7E;
         7'h2B: c = 7'h7C;
         7'h33: c = 7'h3C;
         7'h34: c = 7'h3E;
         7'h35: c = 7'h3F;
         default: begin
            if (p >= 7'h61 && p <= 7'h7A) c = p ^ 7'h20;
            else c = p;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== sv/sac_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface sac_req_if;
   import sac_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sac_rsp_if;
   import sac_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/sac_decode.sv =====
// Scancode classifier and key table lookup.
module sac_decode (
   input  logic              [7:0] scancode,
   input  logic                    shift_held,
   input  logic                    prefix_seen,
   output sac_pkg::dec_type        dec
);
   import sac_pkg::*;

   // Classify the byte in priority order: prefix, prefixed byte, shift, release, make
   always_comb begin
      dec = '0;
      if (scancode == SC_PREFIX) begin
         dec.prefix_set = 1'b1;
      end else if (prefix_seen) begin
         dec.prefix_clr = 1'b1;
      end else if (scancode == SC_LSHIFT || scancode == SC_RSHIFT) begin
         dec.shift_set = 1'b1;
      end else if (scancode == SC_LSHIFT_UP || scancode == SC_RSHIFT_UP) begin
         dec.shift_clr = 1'b1;
      end else if ((scancode & SC_RELEASE_BIT) == 8'h00) begin
         dec.ch   = shift_held ? shift_char(scancode[6:0]) : plain_char(scancode[6:0]);
         dec.push = (dec.ch != 7'h00);
      end
   end

endmodule

// ===== sv/scancode_to_ascii_fifo.sv =====
// Set-1 scancode to ASCII decoder with a character FIFO held in a block memory.
//
// Channels: req carries one request per handshake: operation 0 delivers a raw
// scancode byte, operation 1 reads one character. rsp returns exactly one
// response per request, in order: the popped character (or 0), fifo_empty
// when a read found nothing, dropped when a decoded character met a full FIFO.
// The FIFO holds FIFO_DEPTH - 1 characters.
// Throughput: one request per cycle, sustained while rsp is ready. A request
// enters the read stage, which starts the registered read of the oldest
// entry, then the output register, from which the response is valid and
// taken; a decoded character is written to the memory as its request is
// accepted.
// Reset (synchronous): pointers, shift and prefix flags and both pipeline
// valids clear; memory contents stay undefined and are never returned before
// written.
// Stall: when rsp is not ready a full output register holds, and the read
// stage holds behind it; req.ready drops only once both are full.
module scancode_to_ascii_fifo #(
   parameter int FIFO_DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   sac_req_if.sink   req,
   sac_rsp_if.source rsp
);
   import sac_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [6:0] char_store [FIFO_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             shift_ff, shift_in;
   logic             prefix_ff, prefix_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pop_ff;
   logic             s1_empty_ff;
   logic             s1_drop_ff;
   logic [6:0]       rd_data_ff;

   logic             out_valid_ff, out_valid_in;
   rsp_payload_type  out_ff;

   logic             req_accept;
   logic             is_read;
   logic             out_free;
   logic             s1_adv;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;
   logic             fifo_empty;
   logic             fifo_full;
   logic             do_push;
   logic             do_pop;
   dec_type          dec;

   sac_decode u_decode (
      .scancode    (req.payload.scancode),
      .shift_held  (shift_ff),
      .prefix_seen (prefix_ff),
      .dec         (dec)
   );

   // Handshake and pipeline advance
   assign out_free   = !out_valid_ff || rsp.ready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req.ready  = !s1_valid_ff || out_free;
   assign req_accept = req.valid && req.ready;
   assign is_read    = (req.payload.operation == OP_READ);

   // Ring pointer arithmetic and occupancy
   assign wr_next    = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign fifo_empty = (wr_ptr_ff == rd_ptr_ff);
   assign fifo_full  = (wr_next == rd_ptr_ff);
   assign do_push    = req_accept && !is_read && dec.push && !fifo_full;
   assign do_pop     = req_accept && is_read && !fifo_empty;

   // Next state of pointers and key flags
   always_comb begin
      wr_ptr_in = do_push ? wr_next : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_next : rd_ptr_ff;
      shift_in  = shift_ff;
      prefix_in = prefix_ff;
      if (req_accept && !is_read) begin
         if (dec.shift_set) shift_in = 1'b1;
         if (dec.shift_clr) shift_in = 1'b0;
         if (dec.prefix_set) prefix_in = 1'b1;
         if (dec.prefix_clr) prefix_in = 1'b0;
      end
   end

   // Next valid of the read stage and output register
   always_comb begin
      if (req_accept) s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;

      if (s1_adv) out_valid_in = 1'b1;
      else if (rsp.ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         shift_ff     <= 1'b0;
         prefix_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         shift_ff     <= shift_in;
         prefix_ff    <= prefix_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Character memory: write the pushed character, read the oldest entry
   always_ff @(posedge clock) begin
      if (do_push) char_store[wr_ptr_ff] <= dec.ch;
      if (req_accept) rd_data_ff <= char_store[rd_ptr_ff];
   end

   // Read stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pop_ff   <= do_pop;
         s1_empty_ff <= is_read && fifo_empty;
         s1_drop_ff  <= !is_read && dec.push && fifo_full;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_ff.char_out   <= s1_pop_ff ? rd_data_ff : 7'h00;
         out_ff.fifo_empty <= s1_empty_ff;
         out_ff.dropped    <= s1_drop_ff;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   // Input stalls only when both stages are full and the receiver holds off
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && out_valid_ff && !rsp.ready))
      else $error("request stalled without a full pipeline");

   // A read of an empty FIFO leaves the read pointer alone
   a_empty_read : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_read && fifo_empty) |=> $stable(rd_ptr_ff))
      else $error("read pointer moved on an empty FIFO");

   // A character that meets a full FIFO leaves the write pointer alone
   a_full_push : assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_read && fifo_full) |=> $stable(wr_ptr_ff))
      else $error("write pointer moved on a full FIFO");

   // Reset leaves an empty FIFO and no pending response
   a_reset_state : assert property (@(posedge clock)
      reset |=> (wr_ptr_ff == rd_ptr_ff && !rsp.valid && !s1_valid_ff))
      else $error("state not cleared by reset");

endmodule
